// ----- sv/cav_pkg.sv -----
package cav_pkg;

  // Field widths.
  localparam int CoordW = 32;
  localparam int RadW   = 17;
  localparam int QuoW   = 48;
  localparam int NumW   = 97;
  localparam int DenW   = 66;
  localparam int RemW   = DenW + 1;
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_MIN_RADIUS = 2'd2
  } cfg_reg_e;

  localparam logic [CoordW-1:0] CenterXRst = 32'd32768000;
  localparam logic [CoordW-1:0] CenterYRst = 32'd26214400;
  localparam logic [RadW-1:0]   MinRadRst  = 17'd7;

  // Saturation limits of a Q32.16 magnitude.
  localparam logic [QuoW-1:0] PosLim = 48'h7FFF_FFFF_FFFF;
  localparam logic [QuoW-1:0] NegLim = 48'h8000_0000_0000;

  // Division job handed from the front end to the divider.
  typedef struct packed {
    logic            valid;
    logic            near;
    logic            neg_x;
    logic            neg_y;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [DenW-1:0] den;
  } cav_work_t;

  // Quotients leaving the divider.
  typedef struct packed {
    logic            valid;
    logic            near;
    logic            ovf_x;
    logic            ovf_y;
    logic            neg_x;
    logic            neg_y;
    logic [QuoW-1:0] quo_x;
    logic [QuoW-1:0] quo_y;
  } cav_quo_t;

endpackage

// ----- sv/cav_if.sv -----
// Input channel: one point per word.
interface cav_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// Output channel: one acceleration vector per word.
interface cav_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] accel_x;
  logic signed [47:0] accel_y;
  logic               at_center;
  logic               saturated;

  modport source (output valid, accel_x, accel_y, at_center, saturated, input ready);
  modport sink   (input valid, accel_x, accel_y, at_center, saturated, output ready);
endinterface

// ----- sv/cav_front.sv -----
module cav_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             vel_x_i,
  input  logic signed [31:0]             vel_y_i,
  input  logic [cav_pkg::CoordW-1:0]     center_x_i,
  input  logic [cav_pkg::CoordW-1:0]     center_y_i,
  input  logic [cav_pkg::RadW-1:0]       min_radius_i,
  output cav_pkg::cav_work_t             work_o
);
  import cav_pkg::*;

  // Stage 1: offsets and magnitudes.
  logic               v1_q;
  logic signed [32:0] dx_d, dy_d;
  logic [32:0]        adx1_q, ady1_q, adx1_d, ady1_d;
  logic [31:0]        vx1_q, vy1_q, vx1_d, vy1_d;
  logic               negx1_q, negy1_q;

  always_comb begin
    dx_d   = {center_x_i[31], center_x_i} - {pos_x_i[31], pos_x_i};
    dy_d   = {center_y_i[31], center_y_i} - {pos_y_i[31], pos_y_i};
    adx1_d = dx_d[32] ? (~dx_d + 33'd1) : dx_d;
    ady1_d = dy_d[32] ? (~dy_d + 33'd1) : dy_d;
    vx1_d  = vel_x_i[31] ? (~vel_x_i + 32'd1) : vel_x_i;
    vy1_d  = vel_y_i[31] ? (~vel_y_i + 32'd1) : vel_y_i;
  end

  // Stage 2: squares.
  logic        v2_q;
  logic [63:0] vx2_q, vy2_q;
  logic [65:0] adx2_q, ady2_q;
  logic [32:0] adx2c_q, ady2c_q;
  logic        negx2_q, negy2_q;

  // Stage 3: speed squared and distance squared.
  logic        v3_q;
  logic [63:0] s2_3_q;
  logic [65:0] d2_3_q;
  logic [32:0] adx3_q, ady3_q;
  logic        negx3_q, negy3_q;

  // Stage 4: near test and partial products of the numerators.
  logic            v4_q;
  logic            near4_q;
  logic [64:0]     pxl_q, pxh_q, pyl_q, pyh_q;
  logic [63:0]     s2_4_q;
  logic [65:0]     d2_4_q;
  logic [RadW-1:0] r4_q;
  logic            negx4_q, negy4_q;
  logic [RadW-1:0] r_d;
  logic [33:0]     r2_d;

  always_comb begin
    r_d  = (min_radius_i == '0) ? RadW'(1) : min_radius_i;
    r2_d = {17'd0, r_d} * {17'd0, r_d};
  end

  // Stage 5: assemble the division job.
  cav_work_t       work_q, work_d;
  logic [NumW-1:0] nx_full, ny_full;

  always_comb begin
    nx_full       = {pxh_q, 32'd0} + {32'd0, pxl_q};
    ny_full       = {pyh_q, 32'd0} + {32'd0, pyl_q};
    work_d.valid  = v4_q;
    work_d.near   = near4_q;
    work_d.neg_x  = near4_q ? 1'b0 : negx4_q;
    work_d.neg_y  = near4_q ? 1'b0 : negy4_q;
    work_d.num_x  = near4_q ? {33'd0, s2_4_q} : nx_full;
    work_d.num_y  = near4_q ? '0 : ny_full;
    work_d.den    = near4_q ? {49'd0, r4_q} : d2_4_q;
  end

  // Valid bits and the job register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      work_q <= '0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      work_q <= work_d;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx1_q  <= adx1_d;
      ady1_q  <= ady1_d;
      vx1_q   <= vx1_d;
      vy1_q   <= vy1_d;
      negx1_q <= dx_d[32];
      negy1_q <= dy_d[32];

      vx2_q   <= {32'd0, vx1_q} * {32'd0, vx1_q};
      vy2_q   <= {32'd0, vy1_q} * {32'd0, vy1_q};
      adx2_q  <= {33'd0, adx1_q} * {33'd0, adx1_q};
      ady2_q  <= {33'd0, ady1_q} * {33'd0, ady1_q};
      adx2c_q <= adx1_q;
      ady2c_q <= ady1_q;
      negx2_q <= negx1_q;
      negy2_q <= negy1_q;

      s2_3_q  <= vx2_q + vy2_q;
      d2_3_q  <= adx2_q + ady2_q;
      adx3_q  <= adx2c_q;
      ady3_q  <= ady2c_q;
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;

      near4_q <= ({32'd0, r2_d} >= d2_3_q);
      pxl_q   <= {33'd0, s2_3_q[31:0]} * {32'd0, adx3_q};
      pxh_q   <= {33'd0, s2_3_q[63:32]} * {32'd0, adx3_q};
      pyl_q   <= {33'd0, s2_3_q[31:0]} * {32'd0, ady3_q};
      pyh_q   <= {33'd0, s2_3_q[63:32]} * {32'd0, ady3_q};
      s2_4_q  <= s2_3_q;
      d2_4_q  <= d2_3_q;
      r4_q    <= r_d;
      negx4_q <= negx3_q;
      negy4_q <= negy3_q;
    end
  end

  assign work_o = work_q;

endmodule

// ----- sv/cav_div.sv -----
module cav_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cav_pkg::cav_work_t work_i,
  output cav_pkg::cav_quo_t  quo_o
);
  import cav_pkg::*;

  localparam int Steps = QuoW;

  logic            v_q    [0:Steps];
  logic            near_q [0:Steps];
  logic [DenW-1:0] den_q  [0:Steps];
  logic [RemW-1:0] rem_q  [0:Steps][0:1];
  logic [QuoW-1:0] low_q  [0:Steps][0:1];
  logic [QuoW-1:0] quo_q  [0:Steps][0:1];
  logic            ovf_q  [0:Steps][0:1];
  logic            neg_q  [0:Steps][0:1];

  logic [NumW-1:0] num_in [0:1];
  logic            neg_in [0:1];

  always_comb begin
    num_in[0] = work_i.num_x;
    num_in[1] = work_i.num_y;
    neg_in[0] = work_i.neg_x;
    neg_in[1] = work_i.neg_y;
  end

  // Valid bits of every step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Steps; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= work_i.valid;
      for (int s = 1; s <= Steps; s++) v_q[s] <= v_q[s-1];
    end
  end

  // Entry step: the upper numerator bits seed the remainder. If they already
  // reach the divisor, the quotient needs more than 48 bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= work_i.den;
      near_q[0] <= work_i.near;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= {18'd0, num_in[l][NumW-1:QuoW]};
        low_q[0][l] <= num_in[l][QuoW-1:0];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= ({17'd0, num_in[l][NumW-1:QuoW]} >= work_i.den);
        neg_q[0][l] <= neg_in[l];
      end
    end
  end

  // One quotient bit per step, restoring division on both lanes.
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [RemW-1:0] trial [0:1];
    logic            ge    [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_q[s-1][l][RemW-2:0], low_q[s-1][l][QuoW-1]};
        ge[l]    = (trial[l] >= {1'b0, den_q[s-1]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_q[s-1];
        near_q[s] <= near_q[s-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[s][l] <= ge[l] ? (trial[l] - {1'b0, den_q[s-1]}) : trial[l];
          low_q[s][l] <= {low_q[s-1][l][QuoW-2:0], 1'b0};
          quo_q[s][l] <= {quo_q[s-1][l][QuoW-2:0], ge[l]};
          ovf_q[s][l] <= ovf_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end
  end

  assign quo_o.valid = v_q[Steps];
  assign quo_o.near  = near_q[Steps];
  assign quo_o.ovf_x = ovf_q[Steps][0];
  assign quo_o.ovf_y = ovf_q[Steps][1];
  assign quo_o.neg_x = neg_q[Steps][0];
  assign quo_o.neg_y = neg_q[Steps][1];
  assign quo_o.quo_x = quo_q[Steps][0];
  assign quo_o.quo_y = quo_q[Steps][1];

endmodule

// ----- sv/centripetal_accel_vector_top.sv -----
// Centripetal acceleration of a point about a configurable center.
//
// Input channel in_i carries one point per word: position and velocity in
// signed Q16.16. Output channel out_o returns one word per point: the
// acceleration toward the center in signed Q32.16, the at_center flag and
// the saturated flag. Words come out in the order they went in.
//
// The configuration port writes center_x (index 0), center_y (index 1) and
// min_radius (index 2) when cfg_we_i is high; other indexes are ignored.
// Write only while no point is in flight.
//
// The pipeline has five front-end stages (offsets, squares, sums, partial
// products, job assembly), one divider entry stage, 48 quotient-bit stages
// of the pipelined restoring divider, and the output register.
// A new point is accepted every cycle; the 48-stage divider sets the depth.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_i.ready drops; nothing is lost or repeated. Reset empties the
// pipeline and loads the default center (500.0, 400.0) and min_radius.
module centripetal_accel_vector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cav_in_if.sink                      in_i,
  cav_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [cav_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cav_pkg::CoordW-1:0]  cfg_data_i
);
  import cav_pkg::*;

  logic [CoordW-1:0] center_x_q, center_y_q;
  logic [RadW-1:0]   min_radius_q;
  logic              en;
  cav_work_t         work;
  cav_quo_t          quo;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= CenterXRst;
      center_y_q   <= CenterYRst;
      min_radius_q <= MinRadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:   center_x_q   <= cfg_data_i;
        REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        REG_MIN_RADIUS: min_radius_q <= cfg_data_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished word is held by the receiver.
  logic out_v_q;
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  cav_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .pos_x_i     (in_i.pos_x),
    .pos_y_i     (in_i.pos_y),
    .vel_x_i     (in_i.vel_x),
    .vel_y_i     (in_i.vel_y),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .min_radius_i(min_radius_q),
    .work_o      (work)
  );

  cav_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .work_i(work),
    .quo_o (quo)
  );

  // Saturate and apply the sign.
  logic [QuoW-1:0] lim_x, lim_y, mag_x, mag_y;
  logic            sat_x, sat_y;

  always_comb begin
    lim_x = quo.neg_x ? NegLim : PosLim;
    lim_y = quo.neg_y ? NegLim : PosLim;
    sat_x = quo.ovf_x || (quo.quo_x > lim_x);
    sat_y = quo.ovf_y || (quo.quo_y > lim_y);
    mag_x = sat_x ? lim_x : quo.quo_x;
    mag_y = sat_y ? lim_y : quo.quo_y;
  end

  logic [QuoW-1:0] ax_q, ay_q;
  logic            near_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= quo.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= quo.neg_x ? (~mag_x + QuoW'(1)) : mag_x;
      ay_q   <= quo.neg_y ? (~mag_y + QuoW'(1)) : mag_y;
      near_q <= quo.near;
      sat_q  <= sat_x || sat_y;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.accel_x   = ax_q;
  assign out_o.accel_y   = ay_q;
  assign out_o.at_center = near_q;
  assign out_o.saturated = sat_q;

endmodule

// ----- sv/cav_chk.sv -----
module cav_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] accel_x_i,
  input logic [47:0] accel_y_i,
  input logic        at_center_i,
  input logic        saturated_i
);
  import cav_pkg::*;

  // A stalled word stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(accel_x_i) && $stable(accel_y_i))
    else $error("stalled output word changed");

  // Near the center there is no y component.
  a_near_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && at_center_i |-> accel_y_i == '0)
    else $error("nonzero accel_y at center");

  // Near the center the x component is a plain magnitude.
  a_near_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && at_center_i |-> !accel_x_i[47])
    else $error("negative accel_x at center");

  // A clipped word carries a limit value in some component.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      accel_x_i == PosLim || accel_x_i == NegLim ||
      accel_y_i == PosLim || accel_y_i == NegLim)
    else $error("saturated word without a limit value");

endmodule

bind centripetal_accel_vector_top cav_chk u_cav_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .accel_x_i  (out_o.accel_x),
  .accel_y_i  (out_o.accel_y),
  .at_center_i(out_o.at_center),
  .saturated_i(out_o.saturated)
);

// ----- verif/centripetal_accel_vector_top_test.sv -----
module centripetal_accel_vector_top_test;
  import cav_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it, used to check that such writes are ignored.
  localparam logic [CfgIdxW-1:0] UnusedIdx = 2'd3;
  localparam int LatencyCycles = 55;
  localparam int CycleLimit = 600000;
  localparam int RandomItems = 1200;
  localparam int MaxGap = 17;

  typedef struct {
    logic [QuoW-1:0] accel_x;
    logic [QuoW-1:0] accel_y;
    logic            at_center;
    logic            saturated;
  } accel_word_t;

  // Scoreboard: keeps its own copy of the registers and predicts each word.
  class accel_scoreboard;
    logic [CoordW-1:0] ctr_x;
    logic [CoordW-1:0] ctr_y;
    logic [RadW-1:0]   min_rad;
    accel_word_t       expected_q[$];
    int                mismatches;

    function void reset_regs();
      ctr_x   = CenterXRst;
      ctr_y   = CenterYRst;
      min_rad = MinRadRst;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
      case (idx)
        REG_CENTER_X:   ctr_x = data;
        REG_CENTER_Y:   ctr_y = data;
        REG_MIN_RADIUS: min_rad = data[RadW-1:0];
        default: ;
      endcase
    endfunction

    // Clip a quotient magnitude to Q32.16 and apply the sign.
    function logic [QuoW-1:0] clip_signed(logic [127:0] q, bit neg, ref logic sat);
      logic [127:0] lim;
      logic [QuoW-1:0] m;
      lim = neg ? {80'd0, NegLim} : {80'd0, PosLim};
      if (q > lim) begin
        m = lim[QuoW-1:0];
        sat = 1'b1;
      end else begin
        m = q[QuoW-1:0];
      end
      return neg ? (~m + 1'b1) : m;
    endfunction

    function logic [32:0] mag33(logic signed [32:0] v);
      return v[32] ? (33'd0 - v) : v;
    endfunction

    function accel_word_t predict_accel(logic [31:0] px, logic [31:0] py,
                                        logic [31:0] vx, logic [31:0] vy);
      logic signed [32:0] dx, dy;
      logic [32:0] adx, ady, avx, avy;
      logic [63:0] s2;
      logic [65:0] d2, r2;
      logic [16:0] rad;
      logic [127:0] nx, ny, qx, qy;
      logic sat;
      accel_word_t w;
      dx  = $signed({ctr_x[31], ctr_x}) - $signed({px[31], px});
      dy  = $signed({ctr_y[31], ctr_y}) - $signed({py[31], py});
      adx = mag33(dx);
      ady = mag33(dy);
      avx = mag33({vx[31], vx});
      avy = mag33({vy[31], vy});
      s2  = 64'(avx) * 64'(avx) + 64'(avy) * 64'(avy);
      d2  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
      // A zero radius behaves as the smallest step.
      rad = (min_rad == '0) ? 17'd1 : min_rad;
      r2  = 66'(rad) * 66'(rad);
      sat = 1'b0;
      w.at_center = (r2 >= d2);
      if (w.at_center) begin
        qx = 128'(s2) / 128'(rad);
        w.accel_x = clip_signed(qx, 1'b0, sat);
        w.accel_y = '0;
      end else begin
        nx = 128'(s2) * 128'(adx);
        ny = 128'(s2) * 128'(ady);
        qx = nx / 128'(d2);
        qy = ny / 128'(d2);
        w.accel_x = clip_signed(qx, dx[32], sat);
        w.accel_y = clip_signed(qy, dy[32], sat);
      end
      w.saturated = sat;
      return w;
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py,
                             logic [31:0] vx, logic [31:0] vy);
      expected_q.push_back(predict_accel(px, py, vx, vy));
    endfunction

    function void check_word(accel_word_t got);
      accel_word_t exp_w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output word: ax=%h ay=%h c=%b s=%b",
                   got.accel_x, got.accel_y, got.at_center, got.saturated);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.accel_x !== exp_w.accel_x || got.accel_y !== exp_w.accel_y ||
          got.at_center !== exp_w.at_center || got.saturated !== exp_w.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: exp ax=%h ay=%h c=%b s=%b, got ax=%h ay=%h c=%b s=%b",
                   exp_w.accel_x, exp_w.accel_y, exp_w.at_center, exp_w.saturated,
                   got.accel_x, got.accel_y, got.at_center, got.saturated);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordW-1:0] cfg_data_i;

  cav_in_if  in_ch ();
  cav_out_if out_ch ();

  centripetal_accel_vector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  accel_scoreboard sb = new();
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitors sample the handshake as it stood just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_point(in_ch.pos_x, in_ch.pos_y, in_ch.vel_x, in_ch.vel_y);
  end

  always @(posedge clk_i) begin
    accel_word_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.accel_x   = out_ch.accel_x;
      got.accel_y   = out_ch.accel_y;
      got.at_center = out_ch.at_center;
      got.saturated = out_ch.saturated;
      sb.check_word(got);
    end
  end

  // Receiver: random stalls, with occasional stretches of none.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 40) == 0) recv_idle_on = ~recv_idle_on;
      gap = recv_idle_on ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // The enable drops after the edge that takes the write, so back-to-back writes never
  // schedule two values on it at the same edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py,
                            logic [31:0] vx, logic [31:0] vy);
    int gap;
    if ($urandom_range(0, 40) == 0) send_idle_on = ~send_idle_on;
    gap = send_idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Wait until every predicted word has come back, then let the pipe settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);
  endtask

  // Field values: full range, small values, extremes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Mostly points around the center so both branches are well covered.
  task automatic send_random_point();
    logic [31:0] px, py;
    int span;
    case ($urandom_range(0, 3))
      0: begin
        px = rand_word();
        py = rand_word();
      end
      1: begin
        span = $urandom_range(0, 1) ? 4 : sb.min_rad + 2;
        px = sb.ctr_x + 32'($signed($urandom_range(0, 2 * span)) - span);
        py = sb.ctr_y + 32'($signed($urandom_range(0, 2 * span)) - span);
      end
      default: begin
        px = sb.ctr_x + (rand_word() >>> $urandom_range(0, 16));
        py = sb.ctr_y + (rand_word() >>> $urandom_range(0, 16));
      end
    endcase
    send_point(px, py, rand_word(), rand_word());
  endtask

  task automatic random_phase(int count);
    repeat (count) send_random_point();
    drain();
  endtask

  initial begin
    logic [31:0] cx, cy;
    cycles      = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CENTER_X;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    sb.reset_regs();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset settings.
    cx = sb.ctr_x;
    cy = sb.ctr_y;
    send_point(cx, cy, 32'h0001_0000, 32'h0);                  // exactly at the center
    send_point(cx + 7, cy, 32'h0001_0000, 32'h0);              // distance equals radius
    send_point(cx + 8, cy, 32'h0001_0000, 32'h0);              // just outside radius
    send_point(cx - 5, cy + 5, 32'h8000_0000, 32'h8000_0000);  // just outside radius, saturating
    send_point(cx + 32'h0001_0000, cy, 32'h0, 32'h0);          // zero speed
    send_point(cx + 32'h0064_0000, cy - 32'h0032_0000, 32'h0003_0000, 32'hFFFC_0000);
    send_point(cx - 32'h0064_0000, cy + 32'h0032_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_point(cx + 1, cy - 1, 32'h0000_0001, 32'hFFFF_FFFF);
    send_point(cx + 32'h0000_0100, cy + 32'h0000_0100, 32'h0100_0000, 32'h0);
    drain();

    // Extreme centers, radius 0x10000; the radius data carries junk above bit 16.
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    write_reg(REG_MIN_RADIUS, 32'hFFFF_0000 | 32'h1_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_0000, 32'h8000_FFFF, 32'h0002_0000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    drain();

    // Zero radius acts as one; a write to the unused index changes nothing.
    write_reg(REG_CENTER_X, 32'h0);
    write_reg(REG_CENTER_Y, 32'h0);
    write_reg(REG_MIN_RADIUS, 32'h0);
    write_reg(UnusedIdx, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h1, 32'h0, 32'h0001_0000, 32'h0);
    send_point(32'h1, 32'h1, 32'h0001_0000, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    random_phase(200);

    // Random phases under a range of settings.
    write_reg(REG_MIN_RADIUS, 32'h1);
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    random_phase(200);

    write_reg(REG_MIN_RADIUS, 32'h1_0000);
    write_reg(REG_CENTER_X, 32'h0064_0000);
    write_reg(REG_CENTER_Y, 32'hFF9C_0000);
    random_phase(200);

    repeat (3) begin
      write_reg(REG_CENTER_X, rand_word());
      write_reg(REG_CENTER_Y, rand_word());
      write_reg(REG_MIN_RADIUS, $urandom_range(0, 32'h1_0000));
      random_phase(200);
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cav_pkg.sv
sv/cav_if.sv
sv/cav_front.sv
sv/cav_div.sv
sv/centripetal_accel_vector_top.sv
sv/cav_chk.sv
verif/centripetal_accel_vector_top_test.sv
